/* rtl/uvsp_pkg.sv */
package uvsp_pkg;

    localparam int STEPS_W             = 8;
    localparam int IDX_W               = 16;
    localparam int SLOT_W              = 19;
    localparam int COORD_W             = 16;
    localparam int MAX_STEPS           = 255;
    localparam int RESET_STEPS         = 16;
    localparam int ANGLE_BITS_DEF      = 16;
    localparam int COORD_FRAC_BITS_DEF = 15;

    // Q30 sine datapath
    localparam int Q_FRAC   = 30;
    localparam int MAG_W    = Q_FRAC + 1;
    localparam int NUM_COEF = 6;
    localparam int PROD_W   = 2 * MAG_W;

    localparam int COORD_POS_MAX = 32767;
    localparam int COORD_NEG_MAX = 32768;

    // odd Taylor terms of sin(pi/2 * t), Q30
    localparam logic [MAG_W-1:0] SIN_COEF [0:NUM_COEF-1] = '{
        31'd1686629713,
        31'd693598668,
        31'd85569304,
        31'd5026995,
        31'd172272,
        31'd3864
    };

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } t_sin;

    typedef struct packed {
        logic [IDX_W-1:0]  vertex;
        logic [IDX_W-1:0]  vnext;
        logic              quad_valid;
        logic [SLOT_W-1:0] slot_base;
    } t_idx;

    typedef struct packed {
        logic [IDX_W-1:0]          vertex_number;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      quad_valid;
        logic [SLOT_W-1:0]         quad_slot_base;
        logic [IDX_W-1:0]          slot0_index;
        logic [IDX_W-1:0]          slot1_index;
        logic [IDX_W-1:0]          slot2_index;
        logic [IDX_W-1:0]          slot3_index;
        logic [IDX_W-1:0]          slot4_index;
        logic [IDX_W-1:0]          slot5_index;
    } t_res;

endpackage

/* rtl/uvsp_if.sv */
interface uvsp_in_if import uvsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STEPS_W-1:0] lat_step;
    logic [STEPS_W-1:0] lon_step;

    modport source (output valid, lat_step, lon_step, input ready);
    modport sink   (input valid, lat_step, lon_step, output ready);
endinterface

interface uvsp_out_if import uvsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          vertex_number;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      quad_valid;
    logic [SLOT_W-1:0]         quad_slot_base;
    logic [IDX_W-1:0]          slot0_index;
    logic [IDX_W-1:0]          slot1_index;
    logic [IDX_W-1:0]          slot2_index;
    logic [IDX_W-1:0]          slot3_index;
    logic [IDX_W-1:0]          slot4_index;
    logic [IDX_W-1:0]          slot5_index;

    modport source (output valid, vertex_number, pos_x, pos_y, pos_z, quad_valid,
                    quad_slot_base, slot0_index, slot1_index, slot2_index,
                    slot3_index, slot4_index, slot5_index, input ready);
    modport sink   (input valid, vertex_number, pos_x, pos_y, pos_z, quad_valid,
                    quad_slot_base, slot0_index, slot1_index, slot2_index,
                    slot3_index, slot4_index, slot5_index, output ready);
endinterface

interface uvsp_cfg_if import uvsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STEPS_W-1:0] steps;

    modport source (output valid, steps, input ready);
    modport sink   (input valid, steps, output ready);
endinterface

/* rtl/uv_sphere_point_generator_unit.sv */
// UV sphere point generator. Each beat on i_in carries one latitude/longitude
// grid point; o_out returns its vertex number, its position on a sphere of
// radius 0.5 (signed, COORD_FRAC_BITS fraction bits) and, for points with both
// coordinates below steps, the six triangle indices of the quad it opens.
// One point is accepted per clock unless the output stage is full; a result
// passes through 15 register stages: 4 of reciprocal division into angle
// phases, 8 of Horner sine evaluation (four lanes in parallel), 2 of product
// and rounding, and the output register.
// A two-entry output stage keeps the input open while one result waits; a
// second waiting result stalls the whole pipe. Write steps over i_cfg only
// when no point is in flight; 0 is taken as 1.
module uv_sphere_point_generator_unit import uvsp_pkg::*; #(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uvsp_cfg_if.sink   i_cfg,
    uvsp_in_if.sink    i_in,
    uvsp_out_if.source o_out
);

    localparam int K   = ANGLE_BITS + STEPS_W;
    localparam int NST = 14;
    localparam int DLY = NST - 4;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    // reciprocal table, floor((2^K - 1) / s)
    logic [K-1:0] w_rtab [0:(1 << STEPS_W)-1];
    for (genvar gi = 0; gi < (1 << STEPS_W); gi++) begin : g_rtab
        localparam longint unsigned DIV = (gi == 0) ? 1 : gi;
        localparam logic [63:0] RV = ((64'd1 << K) - 64'd1) / DIV;
        assign w_rtab[gi] = RV[K-1:0];
    end

    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [K-1:0]       r_recip;

    assign i_cfg.ready = 1'b1;
    assign n_steps = (i_cfg.steps == '0) ? STEPS_W'(1)
                   : (i_cfg.steps > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS)
                   : i_cfg.steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_W'(RESET_STEPS);
            r_recip <= w_rtab[STEPS_W'(RESET_STEPS)];
        end else if (i_cfg.valid) begin
            r_steps <= n_steps;
            r_recip <= w_rtab[n_steps];
        end
    end

    // pipeline control: every stage advances unless the skid entry is full
    logic             w_en;
    logic [NST-1:0]   r_vld;
    logic             r_ov, r_skid_v;
    t_res             r_out, r_skid, w_res;
    logic             w_take, w_push;

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;
    assign w_take     = r_ov && o_out.ready;
    assign w_push     = w_en && r_vld[NST-1];

    logic [ANGLE_BITS-1:0] w_lon_ph, w_lat_ph;
    t_idx                  w_idx;
    t_sin                  w_sin_lon, w_cos_lon, w_sin_lat, w_cos_lat;
    logic signed [COORD_W-1:0] w_px, w_py, w_pz;

    uvsp_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lat    (i_in.lat_step),
        .i_lon    (i_in.lon_step),
        .i_steps  (r_steps),
        .i_recip  (r_recip),
        .o_lon_ph (w_lon_ph),
        .o_lat_ph (w_lat_ph),
        .o_idx    (w_idx)
    );

    uvsp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lon (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_lon_ph), .o_res(w_sin_lon)
    );
    uvsp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lon (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_lon_ph + QUARTER), .o_res(w_cos_lon)
    );
    uvsp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lat (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_lat_ph), .o_res(w_sin_lat)
    );
    uvsp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lat (
        .i_clk(i_clk), .i_en(w_en), .i_phase(w_lat_ph + QUARTER), .o_res(w_cos_lat)
    );

    uvsp_coord #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_coord (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_sin_lon (w_sin_lon),
        .i_cos_lon (w_cos_lon),
        .i_sin_lat (w_sin_lat),
        .i_cos_lat (w_cos_lat),
        .o_pos_x   (w_px),
        .o_pos_y   (w_py),
        .o_pos_z   (w_pz)
    );

    // hold index data alongside the sine and coordinate stages
    t_idx r_idx_dly [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx_dly[0] <= w_idx;
            for (int k = 1; k < DLY; k++) begin
                r_idx_dly[k] <= r_idx_dly[k-1];
            end
        end
    end

    t_idx w_fi;
    assign w_fi = r_idx_dly[DLY-1];

    always_comb begin
        w_res.vertex_number  = w_fi.vertex;
        w_res.pos_x          = w_px;
        w_res.pos_y          = w_py;
        w_res.pos_z          = w_pz;
        w_res.quad_valid     = w_fi.quad_valid;
        w_res.quad_slot_base = w_fi.slot_base;
        if (w_fi.quad_valid) begin
            w_res.slot0_index = w_fi.vertex;
            w_res.slot1_index = w_fi.vnext;
            w_res.slot2_index = w_fi.vertex + IDX_W'(1);
            w_res.slot3_index = w_fi.vertex + IDX_W'(1);
            w_res.slot4_index = w_fi.vnext;
            w_res.slot5_index = w_fi.vnext + IDX_W'(1);
        end else begin
            w_res.slot0_index = '0;
            w_res.slot1_index = '0;
            w_res.slot2_index = '0;
            w_res.slot3_index = '0;
            w_res.slot4_index = '0;
            w_res.slot5_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NST-2:0], i_in.valid};
            end
            if (!r_ov || w_take) begin
                if (r_skid_v) begin
                    r_ov     <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_ov <= w_push;
                end
            end else if (w_push) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_take) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.vertex_number  = r_out.vertex_number;
    assign o_out.pos_x          = r_out.pos_x;
    assign o_out.pos_y          = r_out.pos_y;
    assign o_out.pos_z          = r_out.pos_z;
    assign o_out.quad_valid     = r_out.quad_valid;
    assign o_out.quad_slot_base = r_out.quad_slot_base;
    assign o_out.slot0_index    = r_out.slot0_index;
    assign o_out.slot1_index    = r_out.slot1_index;
    assign o_out.slot2_index    = r_out.slot2_index;
    assign o_out.slot3_index    = r_out.slot3_index;
    assign o_out.slot4_index    = r_out.slot4_index;
    assign o_out.slot5_index    = r_out.slot5_index;

endmodule

/* rtl/uvsp_phase.sv */
module uvsp_phase import uvsp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [STEPS_W-1:0]            i_lat,
    input  logic [STEPS_W-1:0]            i_lon,
    input  logic [STEPS_W-1:0]            i_steps,
    input  logic [ANGLE_BITS+STEPS_W-1:0] i_recip,
    output logic [ANGLE_BITS-1:0]         o_lon_ph,
    output logic [ANGLE_BITS-1:0]         o_lat_ph,
    output t_idx                          o_idx
);

    localparam int A = ANGLE_BITS;
    localparam int K = ANGLE_BITS + STEPS_W;
    localparam logic [A-1:0] HALF    = {1'b1, {(A-1){1'b0}}};
    localparam logic [A-1:0] QUARTER = {2'b01, {(A-2){1'b0}}};

    // stage 0: saturate grid point, build numerators
    logic [STEPS_W-1:0] w_lat_c, w_lon_c;
    logic [K-1:0]       n_nlon, n_nlat;
    logic [K-1:0]       r0_nlon, r0_nlat;
    logic [STEPS_W-1:0] r0_s, r0_lat, r0_lon;

    assign w_lat_c = (i_lat > i_steps) ? i_steps : i_lat;
    assign w_lon_c = (i_lon > i_steps) ? i_steps : i_lon;
    assign n_nlon  = (K'(w_lon_c) << A) + K'(i_steps >> 1);
    assign n_nlat  = (K'(w_lat_c) << A) + K'(i_steps);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_nlon <= n_nlon;
            r0_nlat <= n_nlat;
            r0_s    <= i_steps;
            r0_lat  <= w_lat_c;
            r0_lon  <= w_lon_c;
        end
    end

    // stage 1: quotient estimate by reciprocal, vertex and slot math
    logic [2*K-1:0]     w_plon, w_plat;
    logic [IDX_W:0]     w_vsum, w_cell;
    logic               w_qv;
    logic [SLOT_W-1:0]  w_base;
    logic [K-1:0]       r1_q0lon, r1_q0lat, r1_nlon, r1_nlat;
    logic [STEPS_W-1:0] r1_s;
    t_idx               r1_idx;

    assign w_plon = (2*K)'(r0_nlon) * (2*K)'(i_recip);
    assign w_plat = (2*K)'(r0_nlat) * (2*K)'(i_recip);
    assign w_vsum = (IDX_W+1)'(r0_lat) * ((IDX_W+1)'(r0_s) + (IDX_W+1)'(1))
                  + (IDX_W+1)'(r0_lon);
    assign w_cell = (IDX_W+1)'(r0_lat) * (IDX_W+1)'(r0_s) + (IDX_W+1)'(r0_lon);
    assign w_qv   = (r0_lat < r0_s) && (r0_lon < r0_s);
    assign w_base = w_qv ? (SLOT_W'(w_cell) << 2) + (SLOT_W'(w_cell) << 1) : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q0lon          <= w_plon[2*K-1:K];
            r1_q0lat          <= w_plat[2*K-1:K];
            r1_nlon           <= r0_nlon;
            r1_nlat           <= r0_nlat;
            r1_s              <= r0_s;
            r1_idx.vertex     <= w_vsum[IDX_W-1:0];
            r1_idx.vnext      <= '0;
            r1_idx.quad_valid <= w_qv;
            r1_idx.slot_base  <= w_base;
        end
    end

    // stage 2: back-multiply the estimate
    logic [K+STEPS_W-1:0] w_mlon, w_mlat;
    logic [K-1:0]         r2_plon, r2_plat, r2_q0lon, r2_q0lat, r2_nlon, r2_nlat;
    logic [STEPS_W-1:0]   r2_s;
    t_idx                 r2_idx;

    assign w_mlon = (K+STEPS_W)'(r1_q0lon) * (K+STEPS_W)'(r1_s);
    assign w_mlat = (K+STEPS_W)'(r1_q0lat) * (K+STEPS_W)'(r1_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_plon  <= w_mlon[K-1:0];
            r2_plat  <= w_mlat[K-1:0];
            r2_q0lon <= r1_q0lon;
            r2_q0lat <= r1_q0lat;
            r2_nlon  <= r1_nlon;
            r2_nlat  <= r1_nlat;
            r2_s     <= r1_s;
            r2_idx.vertex     <= r1_idx.vertex;
            r2_idx.vnext      <= r1_idx.vertex + IDX_W'(r1_s) + IDX_W'(1);
            r2_idx.quad_valid <= r1_idx.quad_valid;
            r2_idx.slot_base  <= r1_idx.slot_base;
        end
    end

    // stage 3: one correction step, then offset to phase
    logic [K-1:0] w_rlon, w_rlat, w_qlon, w_qlat;
    logic [A-1:0] r3_lon_ph, r3_lat_ph;
    t_idx         r3_idx;

    assign w_rlon = r2_nlon - r2_plon;
    assign w_rlat = r2_nlat - r2_plat;
    assign w_qlon = r2_q0lon + K'(w_rlon >= K'(r2_s));
    assign w_qlat = r2_q0lat + K'(w_rlat >= K'(r2_s));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_lon_ph <= w_qlon[A-1:0] + HALF;
            r3_lat_ph <= w_qlat[A:1] - QUARTER;
            r3_idx    <= r2_idx;
        end
    end

    assign o_lon_ph = r3_lon_ph;
    assign o_lat_ph = r3_lat_ph;
    assign o_idx    = r3_idx;

endmodule

/* rtl/uvsp_sine.sv */
module uvsp_sine import uvsp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output t_sin                  o_res
);

    localparam int A = ANGLE_BITS;
    localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << Q_FRAC;

    // stage 0: quadrant fold
    logic [1:0]       w_q;
    logic [Q_FRAC-1:0] w_t30;
    logic [MAG_W-1:0] w_t;

    assign w_q   = i_phase[A-1:A-2];
    assign w_t30 = {i_phase[A-3:0], {(32-A){1'b0}}};
    assign w_t   = w_q[0] ? ONE - MAG_W'(w_t30) : MAG_W'(w_t30);

    logic [MAG_W-1:0] r_t  [0:6];
    logic [1:0]       r_q  [0:6];
    logic [MAG_W-1:0] r_t2 [1:5];
    logic [MAG_W-1:0] r_acc[2:6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= w_t;
            r_q[0] <= w_q;
            for (int k = 1; k < 7; k++) begin
                r_t[k] <= r_t[k-1];
                r_q[k] <= r_q[k-1];
            end
        end
    end

    // stage 1: t squared
    logic [PROD_W-1:0] w_tt;
    assign w_tt = PROD_W'(r_t[0]) * PROD_W'(r_t[0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2[1] <= MAG_W'(w_tt >> Q_FRAC);
            for (int k = 2; k < 6; k++) begin
                r_t2[k] <= r_t2[k-1];
            end
        end
    end

    // stages 2..6: one Horner term each
    for (genvar gj = 0; gj < NUM_COEF - 1; gj++) begin : g_horner
        logic [MAG_W-1:0]  w_acc_in;
        logic [PROD_W-1:0] w_prod;
        if (gj == 0) begin : g_first
            assign w_acc_in = SIN_COEF[NUM_COEF-1];
        end else begin : g_next
            assign w_acc_in = r_acc[gj+1];
        end
        assign w_prod = PROD_W'(w_acc_in) * PROD_W'(r_t2[gj+1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[gj+2] <= SIN_COEF[NUM_COEF-2-gj] - MAG_W'(w_prod >> Q_FRAC);
            end
        end
    end

    // stage 7: final multiply by t, clamp, sign
    logic [PROD_W-1:0] w_fin;
    logic [MAG_W-1:0]  w_m, w_mc;
    t_sin              r_res;

    assign w_fin = PROD_W'(r_acc[6]) * PROD_W'(r_t[6]);
    assign w_m   = MAG_W'(w_fin >> Q_FRAC);
    assign w_mc  = (w_m > ONE) ? ONE : w_m;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.mag <= w_mc;
            r_res.neg <= r_q[6][1] && (w_mc != '0);
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/uvsp_coord.sv */
module uvsp_coord import uvsp_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_sin                      i_sin_lon,
    input  t_sin                      i_cos_lon,
    input  t_sin                      i_sin_lat,
    input  t_sin                      i_cos_lat,
    output logic signed [COORD_W-1:0] o_pos_x,
    output logic signed [COORD_W-1:0] o_pos_y,
    output logic signed [COORD_W-1:0] o_pos_z
);

    localparam int SH = 2 * Q_FRAC + 1 - COORD_FRAC_BITS;

    function automatic logic [COORD_W-1:0] f_coord(input logic [PROD_W-1:0] mag,
                                                   input logic neg);
        logic [PROD_W-1:0] rnd;
        logic [COORD_W:0]  lim;
        rnd = (mag + (PROD_W'(1) << (SH - 1))) >> SH;
        if (neg) begin
            lim = (rnd > PROD_W'(COORD_NEG_MAX)) ? (COORD_W+1)'(COORD_NEG_MAX)
                                                 : (COORD_W+1)'(rnd);
            lim = (COORD_W+1)'(0) - lim;
        end else begin
            lim = (rnd > PROD_W'(COORD_POS_MAX)) ? (COORD_W+1)'(COORD_POS_MAX)
                                                 : (COORD_W+1)'(rnd);
        end
        return lim[COORD_W-1:0];
    endfunction

    // stage 0: products of lat and lon terms for x and z, sin(lat) scaled for y
    logic [PROD_W-1:0] r_mx, r_my, r_mz;
    logic              r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= PROD_W'(i_sin_lon.mag) * PROD_W'(i_cos_lat.mag);
            r_mz <= PROD_W'(i_cos_lon.mag) * PROD_W'(i_cos_lat.mag);
            r_my <= PROD_W'(i_sin_lat.mag) << Q_FRAC;
            r_nx <= i_sin_lon.neg ^ i_cos_lat.neg;
            r_nz <= i_cos_lon.neg ^ i_cos_lat.neg;
            r_ny <= i_sin_lat.neg;
        end
    end

    // stage 1: halve, round half away from zero, saturate
    logic [COORD_W-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= f_coord(r_mx, r_nx);
            r_py <= f_coord(r_my, r_ny);
            r_pz <= f_coord(r_mz, r_nz);
        end
    end

    assign o_pos_x = signed'(r_px);
    assign o_pos_y = signed'(r_py);
    assign o_pos_z = signed'(r_pz);

endmodule

/* rtl/uvsp_chk.sv */
module uvsp_chk import uvsp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [IDX_W-1:0]   i_vertex,
    input logic               i_qv,
    input logic [SLOT_W-1:0]  i_base,
    input logic [IDX_W-1:0]   i_s0,
    input logic [IDX_W-1:0]   i_s1,
    input logic [IDX_W-1:0]   i_s2,
    input logic [IDX_W-1:0]   i_s3,
    input logic [IDX_W-1:0]   i_s4,
    input logic [IDX_W-1:0]   i_s5
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vertex))
        else $error("result beat dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_noquad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_qv |-> i_base == '0 && i_s0 == '0 && i_s1 == '0 &&
                                 i_s2 == '0 && i_s3 == '0 && i_s4 == '0 && i_s5 == '0)
        else $error("quad fields set without a quad");

    a_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_qv |-> i_s0 == i_vertex && i_s2 == i_s3 && i_s1 == i_s4 &&
                                i_s2 == IDX_W'(i_s0 + IDX_W'(1)) &&
                                i_s5 == IDX_W'(i_s1 + IDX_W'(1)))
        else $error("quad index pattern broken");

endmodule

bind uv_sphere_point_generator_unit uvsp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_vertex    (o_out.vertex_number),
    .i_qv        (o_out.quad_valid),
    .i_base      (o_out.quad_slot_base),
    .i_s0        (o_out.slot0_index),
    .i_s1        (o_out.slot1_index),
    .i_s2        (o_out.slot2_index),
    .i_s3        (o_out.slot3_index),
    .i_s4        (o_out.slot4_index),
    .i_s5        (o_out.slot5_index)
);
